@@ src/ssv_pkg.sv @@
// shared types, codes and constants of the sine synth voice engine
package ssv_pkg;

    // build-time defaults
    localparam int DEF_VOICES       = 8;
    localparam int DEF_SAMPLE_RATE  = 44100;
    localparam int DEF_SINE_ENTRIES = 1024;

    // operation codes
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_FILTER_COEFF = 2'd0;
    localparam logic [1:0] REG_ATTACK_STEP  = 2'd1;
    localparam logic [1:0] REG_RELEASE_STEP = 2'd2;

    // fixed-point constants
    localparam logic [16:0] UNITY          = 17'd65536;
    localparam logic [16:0] ATTACK_RESET   = 17'd149;
    localparam logic [16:0] RELEASE_RESET  = 17'd15;
    localparam longint      MIX_DEN        = 64'sd83230720;
    localparam longint      MIX_LIMIT      = 64'sd131072 * MIX_DEN;
    localparam longint      HALF_PI_Q30    = 64'sd1686629713;
    localparam longint      Q30_ONE        = 64'sd1073741824;

    // base note frequencies of one octave, Q16.16 Hz
    localparam logic [31:0] BASE_FREQ_Q16 [12] = '{
        32'd535809, 32'd567670, 32'd601425, 32'd637188, 32'd675077, 32'd715219,
        32'd757749, 32'd802807, 32'd850544, 32'd901120, 32'd954703, 32'd1011473
    };

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ATTACK,
        MODE_SUSTAIN,
        MODE_RELEASE
    } env_mode_t;

    // one voice record, carried along the ring of cells
    typedef struct packed {
        env_mode_t          mode;
        logic [16:0]        level;
        logic [23:0]        phase;
        logic signed [15:0] filt;
        logic [6:0]         note;
        logic [6:0]         vel;
        logic [16:0]        coeff;
        logic [16:0]        atk;
        logic [16:0]        rel;
    } voice_t;

    localparam voice_t VOICE_RESET = '{
        mode:  MODE_IDLE,
        level: 17'd0,
        phase: 24'd0,
        filt:  16'sd0,
        note:  7'd0,
        vel:   7'd127,
        coeff: UNITY,
        atk:   ATTACK_RESET,
        rel:   RELEASE_RESET
    };

endpackage

@@ src/ssv_if.sv @@
// handshake channel interfaces: note/tick input, sample output, config write
interface ssv_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [6:0] note;
    logic [6:0] velocity;

    modport source (output valid, output op, output note, output velocity, input ready);
    modport sink   (input valid, input op, input note, input velocity, output ready);
endinterface

interface ssv_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] mix_sample;

    modport source (output valid, output mix_sample, input ready);
    modport sink   (input valid, input mix_sample, output ready);
endinterface

interface ssv_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/ssv_cell.sv @@
// one voice cell of the ring: holds a voice record, takes its neighbor's on shift
module ssv_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  ssv_pkg::voice_t d_in,
    output ssv_pkg::voice_t q
);
    import ssv_pkg::*;

    voice_t voice_reg;

    // voice record register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg <= VOICE_RESET;
        end
        else if (shift)
        begin
            voice_reg <= d_in;
        end
    end

    assign q = voice_reg;

endmodule

@@ src/ssv_mixdiv.sv @@
// mix scaling: floor division by the mix denominator with saturation to 18 bits
module ssv_mixdiv #(
    parameter int NW = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    output logic                 done,
    output logic signed [17:0]   quot
);
    import ssv_pkg::*;

    // the denominator is 635 * 2^17: shift out 2^17, then multiply by the reciprocal of 635
    // (exact for every shifted dividend below 2^28)
    localparam logic [28:0] RECIP_635 = 29'd432878594;

    logic [NW-1:0]      off;
    logic [27:0]        n2_reg;
    logic [56:0]        prod_reg;
    logic               hi1_reg;
    logic               lo1_reg;
    logic               hi2_reg;
    logic               lo2_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               done_reg;
    logic signed [17:0] quot_reg;
    logic [17:0]        qraw;

    // offset so the quotient is non-negative
    assign off  = num + NW'(MIX_LIMIT);
    assign qraw = prod_reg[38 +: 18];

    // three-stage pipeline: range check, reciprocal multiply, saturate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            hi1_reg  <= 1'b0;
            lo1_reg  <= 1'b0;
            hi2_reg  <= 1'b0;
            lo2_reg  <= 1'b0;
            n2_reg   <= '0;
            prod_reg <= '0;
            quot_reg <= '0;
        end
        else
        begin
            v1_reg <= start;
            if (start)
            begin
                hi1_reg <= (num >= NW'(MIX_LIMIT));
                lo1_reg <= (num < -NW'(MIX_LIMIT));
                n2_reg  <= off[17 +: 28];
            end

            v2_reg <= v1_reg;
            if (v1_reg)
            begin
                hi2_reg  <= hi1_reg;
                lo2_reg  <= lo1_reg;
                prod_reg <= 57'(n2_reg) * 57'(RECIP_635);
            end

            done_reg <= v2_reg;
            if (v2_reg)
            begin
                if (hi2_reg)
                begin
                    quot_reg <= 18'sd131071;
                end
                else if (lo2_reg)
                begin
                    quot_reg <= {1'b1, 17'd0};
                end
                else
                begin
                    quot_reg <= {~qraw[17], qraw[16:0]};
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ src/polyphonic_sine_synth_voices.sv @@
// top level: voice ring, shared voice update unit and mix output
// note-on and note-off: accepted in idle, then each voice passes the head update once as the ring shifts
// sample tick: an idle voice just shifts on, an active voice steps through sine rom, filter, envelope, gain,
// then the mix state, the reciprocal mix divide and the load of the output register once it is free
// one item at a time; a finished sample waits in the output register while the next beat enters
// reset: all voices idle, control, config and output registers at defaults; no clearing pass
module polyphonic_sine_synth_voices #(
    parameter int VOICES       = ssv_pkg::DEF_VOICES,
    parameter int SAMPLE_RATE  = ssv_pkg::DEF_SAMPLE_RATE,
    parameter int SINE_ENTRIES = ssv_pkg::DEF_SINE_ENTRIES
) (
    input  logic      clk,
    input  logic      rst_n,
    ssv_in_if.sink    in_ch,
    ssv_out_if.source out_ch,
    ssv_cfg_if.sink   cfg
);
    import ssv_pkg::*;

    localparam int IW    = (SINE_ENTRIES > 1) ? $clog2(SINE_ENTRIES) : 1;
    localparam int PW    = 25 + IW;
    localparam int VCW   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SUM_W = 43 + $clog2(VOICES);
    localparam int NW    = SUM_W + 3;
    localparam longint MIX_HALF = MIX_DEN / 2;

    typedef logic signed [15:0] sine_rom_t [SINE_ENTRIES];
    typedef logic [23:0] step_tbl_t [128];

    // sine table from quarter-wave symmetry and a Taylor polynomial in Q30
    function automatic sine_rom_t build_sine();
        sine_rom_t   r;
        logic [63:0] q4;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            q4   = 64'(4 * k);
            quad = q4 / 64'(SINE_ENTRIES);
            rem  = q4 % 64'(SINE_ENTRIES);
            num  = quad[0] ? 64'(SINE_ENTRIES) - rem : rem;
            x    = num * 64'(HALF_PI_Q30) / 64'(SINE_ENTRIES);
            x2   = (x * x) >> 30;
            t    = 64'(Q30_ONE);
            t    = 64'(Q30_ONE) - ((x2 * t) >> 30) / 64'd110;
            t    = 64'(Q30_ONE) - ((x2 * t) >> 30) / 64'd72;
            t    = 64'(Q30_ONE) - ((x2 * t) >> 30) / 64'd42;
            t    = 64'(Q30_ONE) - ((x2 * t) >> 30) / 64'd20;
            t    = 64'(Q30_ONE) - ((x2 * t) >> 30) / 64'd6;
            s = (x * t) >> 30;
            v = (s + 64'd16384) >> 15;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            r[k] = quad[1] ? -16'(v) : 16'(v);
        end
        return r;
    endfunction

    // phase step of each note, Q0.24 of a cycle per sample
    function automatic step_tbl_t build_steps();
        step_tbl_t   r;
        logic [63:0] f;
        logic [63:0] v;
        for (int n = 0; n < 128; n++)
        begin
            f    = 64'(BASE_FREQ_Q16[n % 12]) << (n / 12);
            v    = ((f << 8) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
            r[n] = v[23:0];
        end
        return r;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();
    localparam step_tbl_t STEP_TBL = build_steps();

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_MIX,
        S_DIV,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        ST_ADDR,
        ST_MUL1,
        ST_FILT,
        ST_MUL2,
        ST_ACC
    } step_t;

    state_t             state_reg;
    step_t              step_reg;
    logic [VCW-1:0]     vcnt_reg;
    logic               found_reg;
    logic               out_valid_reg;
    logic signed [17:0] mix_reg;
    logic [16:0]        coeff_cfg_reg;
    logic [16:0]        atk_cfg_reg;
    logic [16:0]        rel_cfg_reg;

    logic [1:0]         op_reg;
    logic [6:0]         note_reg;
    logic [6:0]         vel_reg;
    logic signed [15:0] rom_q_reg;
    logic signed [33:0] p1_reg;
    logic signed [15:0] y_reg;
    logic [16:0]        lvl_reg;
    env_mode_t          emode_reg;
    logic signed [33:0] p2_reg;
    logic signed [SUM_W-1:0] sum_reg;

    voice_t             cell_q [VOICES];
    voice_t             head;
    voice_t             head_new;
    logic               shift;
    logic               accept;
    logic               active_tick;
    logic [PW-1:0]      idx_prod;
    logic [IW-1:0]      rom_addr;
    logic signed [34:0] acc;
    logic [17:0]        lvl_up;
    logic [16:0]        lvl_env;
    env_mode_t          mode_env;
    logic signed [41:0] p3;
    logic signed [NW-1:0] mix_num;
    logic               div_start;
    logic               div_done;
    logic signed [17:0] div_q;

    assign head        = cell_q[0];
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign active_tick = (state_reg == S_RUN) && (op_reg == OP_TICK)
                         && (head.mode != MODE_IDLE);

    // ring of voice cells, the head feeds back through the update unit
    genvar gi;
    generate
        for (gi = 0; gi < VOICES; gi++)
        begin : g_cell
            if (gi == VOICES - 1)
            begin : g_last
                ssv_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d_in  (head_new),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_mid
                ssv_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d_in  (cell_q[gi + 1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    // sine rom address from the head voice's phase
    assign idx_prod = PW'(head.phase) * PW'(SINE_ENTRIES);
    assign rom_addr = idx_prod[24 +: IW];

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[rom_addr];
    end

    // one-pole filter sum
    assign acc = 35'(p1_reg) + 35'(head.filt * $signed({1'b0, UNITY - head.coeff}))
                 + 35'sd32768;

    // envelope update
    assign lvl_up = {1'b0, head.level} + {1'b0, head.atk};
    always_comb
    begin
        lvl_env  = head.level;
        mode_env = head.mode;
        case (head.mode)
            MODE_ATTACK:
            begin
                if (lvl_up >= {1'b0, UNITY})
                begin
                    lvl_env  = UNITY;
                    mode_env = MODE_SUSTAIN;
                end
                else
                begin
                    lvl_env = lvl_up[16:0];
                end
            end
            MODE_RELEASE:
            begin
                if (head.rel >= head.level)
                begin
                    lvl_env  = 17'd0;
                    mode_env = MODE_IDLE;
                end
                else
                begin
                    lvl_env = head.level - head.rel;
                end
            end
            default:
            begin
                lvl_env  = head.level;
                mode_env = head.mode;
            end
        endcase
    end

    // velocity gain product
    assign p3 = 42'(p2_reg) * 42'($signed({1'b0, head.vel}));

    // head record update and ring shift
    always_comb
    begin
        head_new = head;
        shift    = 1'b0;
        if (state_reg == S_RUN)
        begin
            case (op_reg)
                OP_NOTE_ON:
                begin
                    shift = 1'b1;
                    if (!found_reg && head.mode == MODE_IDLE)
                    begin
                        head_new.note  = note_reg;
                        head_new.vel   = vel_reg;
                        head_new.coeff = (coeff_cfg_reg > UNITY) ? UNITY : coeff_cfg_reg;
                        head_new.atk   = atk_cfg_reg;
                        head_new.rel   = rel_cfg_reg;
                        head_new.phase = 24'd0;
                        head_new.level = 17'd0;
                        head_new.mode  = MODE_ATTACK;
                    end
                end
                OP_NOTE_OFF:
                begin
                    shift = 1'b1;
                    if (head.mode != MODE_IDLE && head.note == note_reg)
                    begin
                        head_new.mode = MODE_RELEASE;
                    end
                end
                default:
                begin
                    if (head.mode == MODE_IDLE)
                    begin
                        shift = 1'b1;
                    end
                    else if (step_reg == ST_ACC)
                    begin
                        shift          = 1'b1;
                        head_new.phase = head.phase + STEP_TBL[head.note];
                        head_new.filt  = y_reg;
                        head_new.level = lvl_reg;
                        head_new.mode  = emode_reg;
                    end
                end
            endcase
        end
    end

    // mix numerator: 3 * sum + half the denominator
    assign mix_num   = (NW'(sum_reg) <<< 1) + NW'(sum_reg) + NW'(MIX_HALF);
    assign div_start = (state_reg == S_MIX);

    ssv_mixdiv #(
        .NW (NW)
    ) u_mixdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mix_num),
        .done  (div_done),
        .quot  (div_q)
    );

    // voice datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_ch.op;
            note_reg <= in_ch.note;
            vel_reg  <= in_ch.velocity;
            sum_reg  <= '0;
        end
        if (active_tick)
        begin
            case (step_reg)
                ST_MUL1:
                begin
                    p1_reg <= 34'(rom_q_reg) * 34'($signed({1'b0, head.coeff}));
                end
                ST_FILT:
                begin
                    y_reg     <= acc[31:16];
                    lvl_reg   <= lvl_env;
                    emode_reg <= mode_env;
                end
                ST_MUL2:
                begin
                    p2_reg <= 34'(y_reg) * 34'($signed({1'b0, lvl_reg}));
                end
                ST_ACC:
                begin
                    sum_reg <= sum_reg + SUM_W'(p3);
                end
                default:
                begin
                    p1_reg <= p1_reg;
                end
            endcase
        end
    end

    // control state machine, config registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_ADDR;
            vcnt_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            mix_reg       <= '0;
            coeff_cfg_reg <= UNITY;
            atk_cfg_reg   <= ATTACK_RESET;
            rel_cfg_reg   <= RELEASE_RESET;
        end
        else
        begin
            // config writes
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_FILTER_COEFF: coeff_cfg_reg <= cfg.data;
                    REG_ATTACK_STEP:  atk_cfg_reg   <= cfg.data;
                    REG_RELEASE_STEP: rel_cfg_reg   <= cfg.data;
                    default:          coeff_cfg_reg <= coeff_cfg_reg;
                endcase
            end

            // output beat taken, unless a new sample is loaded in the same cycle
            if (out_valid_reg && out_ch.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (in_ch.op == OP_NOTE_ON || in_ch.op == OP_NOTE_OFF
                                   || in_ch.op == OP_TICK))
                    begin
                        state_reg <= S_RUN;
                        step_reg  <= ST_ADDR;
                        vcnt_reg  <= '0;
                        found_reg <= 1'b0;
                    end
                end
                S_RUN:
                begin
                    if (active_tick)
                    begin
                        step_reg <= (step_reg == ST_ACC) ? ST_ADDR : step_t'(step_reg + 3'd1);
                    end
                    if (op_reg == OP_NOTE_ON && head.mode == MODE_IDLE)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (shift)
                    begin
                        if (vcnt_reg == VCW'(VOICES - 1))
                        begin
                            vcnt_reg  <= '0;
                            state_reg <= (op_reg == OP_TICK) ? S_MIX : S_IDLE;
                        end
                        else
                        begin
                            vcnt_reg <= vcnt_reg + 1'b1;
                        end
                    end
                end
                S_MIX:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        mix_reg       <= div_q;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.mix_sample = mix_reg;

endmodule
